### rtl/core/lpfd_pkg.sv
// Types and constants shared by the length-prefixed frame deframer.
// Depends on nothing; imported by length_prefixed_frame_deframer_top.
package lpfd_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       chunk_end;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       in_binary;
        logic       frame_first;
        logic       frame_last;
        logic [1:0] error_code;
    } out_t;

    typedef enum logic [1:0] {
        PH_PREFIX  = 2'd0,
        PH_HEADER  = 2'd1,
        PH_BINARY  = 2'd2,
        PH_DISCARD = 2'd3
    } phase_t;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_ZERO_HDR = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG = 2'd2;

    localparam logic CFG_MAX_HEADER = 1'b0;
    localparam logic CFG_MAX_BINARY = 1'b1;

    localparam logic [31:0] MAX_HEADER_RESET = 32'd1048576;
    localparam logic [31:0] MAX_BINARY_RESET = 32'd16777216;

    // prefix byte index of the last binary-length byte
    localparam logic [2:0] PREFIX_LAST = 3'd7;

endpackage

### rtl/core/length_prefixed_frame_deframer_top.sv
// Length-prefixed frame deframer, single module.
// Depends on lpfd_pkg for payload structs, phase enum and codes.
//
// Usage:
//   in channel (in_valid/in_ready/in_data): one stream byte per request, with
//   chunk_end marking the last byte of a received chunk. Each frame starts with
//   an 8-byte prefix: big-endian header length, then big-endian binary length.
//   out channel (out_valid/out_ready/out_data): one payload byte per request,
//   tagged header/binary, first and last; or an error request (code 1 for a
//   zero header length, code 2 for a length above its limit), after which the
//   rest of the chunk is dropped. Other prefix bytes and dropped bytes give no request.
//   cfg port: cfg_we writes cfg_data into limit cfg_index (0 header, 1 binary).
//   Output: each accepted byte's result is registered and shown in the next cycle.
//   Throughput: one byte per cycle while in_ready is high; all decoding is one
//   pass of phase, counter and 32-bit compare logic between the input handshake
//   and the output register.
//   Stall: in_ready stays high while the output register is empty or being
//   taken; when the receiver holds out_ready low with a result pending, input
//   stops in that same cycle and resumes once the result is taken.
//   Reset: phase returns to prefix gathering, limits return to 1048576 and
//   16777216, output register empties.
module length_prefixed_frame_deframer_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  lpfd_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output lpfd_pkg::out_t  out_data,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [31:0]     cfg_data
);
    import lpfd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  prefix_count_reg, prefix_count_next;
    logic [31:0] header_len_reg, header_len_next;
    logic [31:0] binary_len_reg, binary_len_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [31:0] max_header_reg, max_binary_reg;
    logic        out_valid_reg;
    out_t        out_data_reg;

    logic        in_fire;
    logic        res_valid;
    out_t        res;
    logic [31:0] rem_dec;
    logic        rem_le_one;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign rem_dec    = remaining_reg - {31'd0, (remaining_reg != 32'd0)};
    assign rem_le_one = (remaining_reg[31:1] == 31'd0);

    always_comb
    begin
        phase_next        = phase_reg;
        prefix_count_next = prefix_count_reg;
        header_len_next   = header_len_reg;
        binary_len_next   = binary_len_reg;
        remaining_next    = remaining_reg;
        res_valid         = 1'b0;
        res               = '0;
        if (in_fire)
        begin
            case (phase_reg)
                PH_PREFIX:
                begin
                    if (!prefix_count_reg[2])
                        header_len_next = {header_len_reg[23:0], in_data.in_byte};
                    else
                        binary_len_next = {binary_len_reg[23:0], in_data.in_byte};
                    prefix_count_next = prefix_count_reg + 3'd1;
                    if (prefix_count_reg == PREFIX_LAST)
                    begin
                        prefix_count_next = 3'd0;
                        if (header_len_next == 32'd0)
                            res.error_code = ERR_ZERO_HDR;
                        else if (header_len_next > max_header_reg ||
                                 binary_len_next > max_binary_reg)
                            res.error_code = ERR_TOO_LONG;
                        if (res.error_code != ERR_NONE)
                        begin
                            res_valid  = 1'b1;
                            phase_next = in_data.chunk_end ? PH_PREFIX : PH_DISCARD;
                        end
                        else
                        begin
                            phase_next     = PH_HEADER;
                            remaining_next = header_len_next;
                        end
                    end
                end
                PH_HEADER:
                begin
                    res_valid       = 1'b1;
                    res.out_byte    = in_data.in_byte;
                    res.frame_first = (remaining_reg == header_len_reg);
                    res.frame_last  = rem_le_one && (binary_len_reg == 32'd0);
                    remaining_next  = rem_dec;
                    if (rem_dec == 32'd0)
                    begin
                        if (binary_len_reg == 32'd0)
                        begin
                            phase_next        = PH_PREFIX;
                            prefix_count_next = 3'd0;
                        end
                        else
                        begin
                            phase_next     = PH_BINARY;
                            remaining_next = binary_len_reg;
                        end
                    end
                end
                PH_BINARY:
                begin
                    res_valid      = 1'b1;
                    res.out_byte   = in_data.in_byte;
                    res.in_binary  = 1'b1;
                    res.frame_last = rem_le_one;
                    remaining_next = rem_dec;
                    if (rem_dec == 32'd0)
                    begin
                        phase_next        = PH_PREFIX;
                        prefix_count_next = 3'd0;
                    end
                end
                default:
                begin
                    if (in_data.chunk_end)
                    begin
                        phase_next        = PH_PREFIX;
                        prefix_count_next = 3'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_PREFIX;
            prefix_count_reg <= 3'd0;
            header_len_reg   <= 32'd0;
            binary_len_reg   <= 32'd0;
            remaining_reg    <= 32'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            prefix_count_reg <= prefix_count_next;
            header_len_reg   <= header_len_next;
            binary_len_reg   <= binary_len_next;
            remaining_reg    <= remaining_next;
            if (in_ready)
                out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            out_data_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_header_reg <= MAX_HEADER_RESET;
            max_binary_reg <= MAX_BINARY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_HEADER: max_header_reg <= cfg_data;
                CFG_MAX_BINARY: max_binary_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // payload phases never run with nothing left to count
    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER || phase_reg == PH_BINARY) |-> remaining_reg != 32'd0)
        else $error("payload phase with zero remaining count");

    a_discard_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_PREFIX) |-> prefix_count_reg == 3'd0)
        else $error("prefix count not cleared outside prefix phase");

    a_prefix_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && phase_reg == PH_PREFIX && prefix_count_reg != PREFIX_LAST)
        |=> !out_valid_reg)
        else $error("result produced for a prefix byte");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.error_code != ERR_NONE) |->
        (out_data_reg.out_byte == 8'd0 && !out_data_reg.in_binary &&
         !out_data_reg.frame_first && !out_data_reg.frame_last))
        else $error("error result carries payload fields");

    a_error_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && res_valid && res.error_code != ERR_NONE) |=>
        (phase_reg == PH_PREFIX || phase_reg == PH_DISCARD))
        else $error("error did not leave frame phases");

endmodule
